>>> src/u16d_pkg.sv
`default_nettype none

package u16d_pkg;

  // UTF-16 surrogate tags (top six bits of a code unit)
  localparam logic [5:0] LeadTag  = 6'b110110;
  localparam logic [5:0] TrailTag = 6'b110111;

  // offset added to a combined surrogate pair
  localparam logic [20:0] SuppBase = 21'h010000;

  // one queue entry: the results caused by one accepted unit
  typedef struct packed {
    logic        two;        // lone lead flushed, then the unit itself
    logic        has_point;  // 0 only for a bare end marker
    logic        is_last;    // final beat of the string
    logic [20:0] cp_a;       // first code point
    logic [15:0] cp_b;       // second code point (the unit), when two
    logic [15:0] cnt_a;      // emitted count carried by the first beat
  } u16d_entry_t;

  // front status, visible to checks at the top level
  typedef struct packed {
    logic        lead_pending;
    logic [15:0] emitted;
  } u16d_status_t;

endpackage

`default_nettype wire

>>> src/utf16_to_utf32_decoder_unit.sv
`default_nettype none

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+--------------------------------------
// input    | in        | in_valid_i / in_ready_o   | code_unit_i, last_unit_i
// output   | out       | out_valid_o / out_ready_i | code_point_o, has_point_o, is_last_o,
//          |           |                           | out_count_o
// config   | in        | out_limit_we_i            | out_limit_i
//
// One code unit is accepted per cycle while the result queue has room; a beat passes
// through the queue entry and then the output register before it appears.
// A flushed lone lead followed by its unit gives two beats, which the back end presents
// in turn; the queue (QueueDepth entries) absorbs that so the front keeps going.
// Reset clears the held lead, the emitted count and the queue; the limit returns to 65535.
// Output stalls back up through the queue; the input stalls only when the queue is full.

module utf16_to_utf32_decoder_unit #(
  parameter int QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        last_unit_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [20:0]      code_point_o,
  output logic             has_point_o,
  output logic             is_last_o,
  output logic [15:0]      out_count_o,
  input  wire logic        out_limit_we_i,
  input  wire logic [15:0] out_limit_i
);
  import u16d_pkg::*;

  u16d_entry_t  push_entry, head_entry;
  u16d_status_t front_status;
  logic         q_push, q_pop, q_full, q_empty;

  // classification and string state
  u16d_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .code_unit_i    (code_unit_i),
    .last_unit_i    (last_unit_i),
    .out_limit_we_i (out_limit_we_i),
    .out_limit_i    (out_limit_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (push_entry),
    .status_o       (front_status)
  );

  // result queue between the two halves
  u16d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_entry),
    .pop_i       (q_pop),
    .pop_data_o  (head_entry),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // beat sequencing and output register
  u16d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_entry_i    (head_entry),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_point_o (code_point_o),
    .has_point_o  (has_point_o),
    .is_last_o    (is_last_o),
    .out_count_o  (out_count_o)
  );

  // the front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("push into full result queue");

  // end of string leaves no held lead and a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_unit_i) |=>
      (!front_status.lead_pending && (front_status.emitted == 16'd0)))
    else $error("string state not cleared after last unit");

  // a beat without a code point is always an end marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_point_o) |-> is_last_o)
    else $error("bare beat not marked last");

endmodule

`default_nettype wire

>>> src/u16d_front.sv
`default_nettype none

module u16d_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [15:0]           code_unit_i,
  input  wire logic                  last_unit_i,
  input  wire logic                  out_limit_we_i,
  input  wire logic [15:0]           out_limit_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output u16d_pkg::u16d_entry_t      q_entry_o,
  output u16d_pkg::u16d_status_t     status_o
);
  import u16d_pkg::*;

  logic [15:0] limit_val_q;
  logic        lead_pending_q, lead_pending_d;
  logic [9:0]  lead_bits_q, lead_bits_d;
  logic [15:0] emitted_q, emitted_d;

  logic        accept;
  logic        is_lead, is_trail;
  logic        pair, flush, handle, hold, emit_u;
  logic [15:0] cnt1, cnt_final;
  logic [20:0] pair_cp;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // classify the incoming unit
  assign is_lead  = (code_unit_i[15:10] == LeadTag);
  assign is_trail = (code_unit_i[15:10] == TrailTag);
  assign pair     = lead_pending_q && is_trail;
  assign flush    = lead_pending_q && !is_trail;
  assign cnt1     = emitted_q + {15'd0, (pair || flush)};
  assign handle   = !pair && (cnt1 < limit_val_q);
  assign hold     = handle && is_lead && !last_unit_i;
  assign emit_u   = handle && !(is_lead && !last_unit_i);
  assign cnt_final = cnt1 + {15'd0, emit_u};
  assign pair_cp  = SuppBase + {1'b0, lead_bits_q, code_unit_i[9:0]};

  // build the queue entry
  always_comb begin
    q_entry_o.two       = flush && emit_u;
    q_entry_o.has_point = pair || flush || emit_u;
    q_entry_o.is_last   = last_unit_i;
    q_entry_o.cp_b      = code_unit_i;
    if (pair) begin
      q_entry_o.cp_a = pair_cp;
    end else if (flush) begin
      q_entry_o.cp_a = {5'd0, LeadTag, lead_bits_q};
    end else if (emit_u) begin
      q_entry_o.cp_a = {5'd0, code_unit_i};
    end else begin
      q_entry_o.cp_a = '0;
    end
    q_entry_o.cnt_a = (flush && emit_u) ? cnt1 : cnt_final;
  end

  assign q_push_o = accept && (pair || flush || emit_u || last_unit_i);

  // next string state
  always_comb begin
    lead_pending_d = lead_pending_q;
    lead_bits_d    = lead_bits_q;
    emitted_d      = emitted_q;
    if (accept) begin
      if (last_unit_i) begin
        lead_pending_d = 1'b0;
        lead_bits_d    = '0;
        emitted_d      = '0;
      end else begin
        lead_pending_d = hold;
        lead_bits_d    = hold ? code_unit_i[9:0] : 10'd0;
        emitted_d      = cnt_final;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pending_q <= 1'b0;
      lead_bits_q    <= '0;
      emitted_q      <= '0;
    end else begin
      lead_pending_q <= lead_pending_d;
      lead_bits_q    <= lead_bits_d;
      emitted_q      <= emitted_d;
    end
  end

  // output limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_val_q <= 16'hFFFF;
    end else if (out_limit_we_i) begin
      limit_val_q <= out_limit_i;
    end
  end

  assign status_o.lead_pending = lead_pending_q;
  assign status_o.emitted      = emitted_q;

endmodule

`default_nettype wire

>>> src/u16d_fifo.sv
`default_nettype none

module u16d_fifo #(
  parameter int Depth = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire u16d_pkg::u16d_entry_t push_data_i,
  input  wire logic                  pop_i,
  output u16d_pkg::u16d_entry_t      pop_data_o,
  output logic                       full_o,
  output logic                       empty_o
);
  import u16d_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  u16d_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/u16d_back.sv
`default_nettype none

module u16d_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire u16d_pkg::u16d_entry_t q_entry_i,
  input  wire logic                  q_empty_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [20:0]                code_point_o,
  output logic                       has_point_o,
  output logic                       is_last_o,
  output logic [15:0]                out_count_o
);
  import u16d_pkg::*;

  logic        valid_q, valid_d;
  logic        sec_pend_q, sec_pend_d;
  logic [20:0] cp_q, cp_d;
  logic        has_q, has_d;
  logic        last_q, last_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] sec_cp_q, sec_cp_d;
  logic        sec_last_q, sec_last_d;
  logic [15:0] sec_cnt_q, sec_cnt_d;
  logic        load;

  // output register is free, or its beat leaves this cycle
  assign load    = !valid_q || out_ready_i;
  assign q_pop_o = load && !sec_pend_q && !q_empty_i;

  // pick the next beat: pending second result first, then the queue head
  always_comb begin
    valid_d    = valid_q;
    sec_pend_d = sec_pend_q;
    cp_d       = cp_q;
    has_d      = has_q;
    last_d     = last_q;
    cnt_d      = cnt_q;
    sec_cp_d   = sec_cp_q;
    sec_last_d = sec_last_q;
    sec_cnt_d  = sec_cnt_q;
    if (load) begin
      if (sec_pend_q) begin
        valid_d    = 1'b1;
        sec_pend_d = 1'b0;
        cp_d       = {5'd0, sec_cp_q};
        has_d      = 1'b1;
        last_d     = sec_last_q;
        cnt_d      = sec_cnt_q;
      end else if (!q_empty_i) begin
        valid_d    = 1'b1;
        sec_pend_d = q_entry_i.two;
        cp_d       = q_entry_i.cp_a;
        has_d      = q_entry_i.has_point;
        last_d     = q_entry_i.is_last && !q_entry_i.two;
        cnt_d      = q_entry_i.cnt_a;
        sec_cp_d   = q_entry_i.cp_b;
        sec_last_d = q_entry_i.is_last;
        sec_cnt_d  = q_entry_i.cnt_a + 16'd1;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      sec_pend_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      sec_pend_q <= sec_pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cp_q       <= cp_d;
    has_q      <= has_d;
    last_q     <= last_d;
    cnt_q      <= cnt_d;
    sec_cp_q   <= sec_cp_d;
    sec_last_q <= sec_last_d;
    sec_cnt_q  <= sec_cnt_d;
  end

  assign out_valid_o  = valid_q;
  assign code_point_o = cp_q;
  assign has_point_o  = has_q;
  assign is_last_o    = last_q;
  assign out_count_o  = cnt_q;

endmodule

`default_nettype wire

>>> verif/tb_utf16_to_utf32_decoder_unit.sv
`timescale 1ns / 1ps

import u16d_pkg::*;

// one output beat as the decoder should present it
typedef struct packed {
  logic [20:0] code_point;
  logic        has_point;
  logic        is_last;
  logic [15:0] out_count;
} point_beat_t;

// Tracks the decoder's string state and the code points still due on the output
class utf32_scoreboard;
  point_beat_t due_points[$];
  logic        lead_held;
  logic [9:0]  lead_lo;
  logic [15:0] emitted;
  logic [15:0] limit;
  int          errors;

  function new();
    lead_held = 1'b0;
    lead_lo   = '0;
    emitted   = '0;
    limit     = 16'hFFFF;
    errors    = 0;
  endfunction

  function void set_limit(logic [15:0] v);
    limit = v;
  endfunction

  function int outstanding();
    return due_points.size();
  endfunction

  // work out the beats caused by one accepted code unit
  function void note_unit(logic [15:0] u, logic last);
    point_beat_t beats[2];
    int          n;
    bit          handle;
    n      = 0;
    handle = 1'b1;
    // a held lead is either paired with a trail or flushed on its own
    if (lead_held) begin
      lead_held = 1'b0;
      emitted   = emitted + 16'd1;
      if (u[15:10] == TrailTag) begin
        beats[n] = '{SuppBase + {1'b0, lead_lo, u[9:0]}, 1'b1, 1'b0, emitted};
        handle   = 1'b0;
      end else begin
        beats[n] = '{{5'b0, LeadTag, lead_lo}, 1'b1, 1'b0, emitted};
      end
      n++;
      lead_lo = '0;
    end
    // the unit itself, unless the limit has been reached
    if (handle && emitted < limit) begin
      if (u[15:10] == LeadTag && !last) begin
        lead_held = 1'b1;
        lead_lo   = u[9:0];
      end else begin
        emitted  = emitted + 16'd1;
        beats[n] = '{{5'b0, u}, 1'b1, 1'b0, emitted};
        n++;
      end
    end
    // end of string: mark the final beat, or give a bare end marker
    if (last) begin
      if (n == 0) begin
        beats[0] = '{21'd0, 1'b0, 1'b1, emitted};
        n = 1;
      end else begin
        beats[n-1].is_last = 1'b1;
      end
      lead_held = 1'b0;
      lead_lo   = '0;
      emitted   = '0;
    end
    for (int k = 0; k < n; k++) due_points.push_back(beats[k]);
  endfunction

  // compare one accepted output beat with the oldest one due
  function void check_beat(logic [20:0] cp, logic has, logic lst, logic [15:0] cnt);
    point_beat_t want;
    if (due_points.size() == 0) begin
      $error("unexpected beat: code_point %h has_point %b is_last %b out_count %0d",
             cp, has, lst, cnt);
      errors++;
      return;
    end
    want = due_points.pop_front();
    if (cp !== want.code_point) begin
      $error("code_point: expected %h, got %h", want.code_point, cp);
      errors++;
    end
    if (has !== want.has_point) begin
      $error("has_point: expected %b, got %b", want.has_point, has);
      errors++;
    end
    if (lst !== want.is_last) begin
      $error("is_last: expected %b, got %b", want.is_last, lst);
      errors++;
    end
    if (cnt !== want.out_count) begin
      $error("out_count: expected %0d, got %0d", want.out_count, cnt);
      errors++;
    end
  endfunction
endclass

module tb_utf16_to_utf32_decoder_unit;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 12;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [15:0] code_unit  = '0;
  logic        last_unit  = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [20:0] code_point;
  logic        has_point;
  logic        is_last;
  logic [15:0] out_count;
  logic        limit_we   = 1'b0;
  logic [15:0] limit_val  = '0;

  utf32_scoreboard board = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int used_units    = 0;
  int cycle_count   = 0;

  utf16_to_utf32_decoder_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .code_unit_i    (code_unit),
    .last_unit_i    (last_unit),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .code_point_o   (code_point),
    .has_point_o    (has_point),
    .is_last_o      (is_last),
    .out_count_o    (out_count),
    .out_limit_we_i (limit_we),
    .out_limit_i    (limit_val)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("utf16_to_utf32_decoder_unit: mismatch");
      $finish;
    end
  end

  // receiver: random back-pressure, check every accepted beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_beat(code_point, has_point, is_last, out_count);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // present one code unit, with random gaps before it, and wait until it is accepted
  task automatic send_unit(input logic [15:0] u, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_unit <= u;
    last_unit <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_unit(u, last);
    used_units++;
  endtask

  // stop sending and let every due code point come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // limit writes only happen with nothing in flight
  task automatic write_limit(input logic [15:0] v);
    wait_drained();
    limit_we  <= 1'b1;
    limit_val <= v;
    @(posedge clk);
    limit_we <= 1'b0;
    board.set_limit(v);
  endtask

  // non-surrogate unit, biased towards ASCII
  function automatic logic [15:0] plain_unit();
    logic [15:0] u;
    u = ($urandom_range(1) == 0) ? 16'($urandom_range(127)) : 16'($urandom);
    if (u[15:11] == 5'b11011) u[13] = ~u[13];
    return u;
  endfunction

  // anything goes: corners, lone surrogates, raw values
  function automatic logic [15:0] noisy_unit();
    logic [15:0] u;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(7))
          0: u = 16'h0000;
          1: u = 16'hFFFF;
          2: u = 16'hD800;
          3: u = 16'hDBFF;
          4: u = 16'hDC00;
          5: u = 16'hDFFF;
          6: u = 16'hD7FF;
          default: u = 16'hE000;
        endcase
      end
      1: u = {LeadTag, 10'($urandom_range(1023))};
      2: u = {TrailTag, 10'($urandom_range(1023))};
      default: u = 16'($urandom);
    endcase
    return u;
  endfunction

  // one string; well-formed ones carry proper pairs, the rest is noise
  task automatic send_string(input int len, input bit good);
    int i;
    i = 0;
    while (i < len) begin
      if (good && i + 1 < len && $urandom_range(3) == 0) begin
        send_unit({LeadTag, 10'($urandom_range(1023))}, 1'b0);
        send_unit({TrailTag, 10'($urandom_range(1023))}, i + 2 == len);
        i += 2;
      end else begin
        send_unit(good ? plain_unit() : noisy_unit(), i + 1 == len);
        i++;
      end
    end
  endtask

  // random strings under one idling setting, with the odd limit change between strings
  task automatic run_phase(input int snd_pct, input int rcv_pct, input int target);
    int          start;
    int          len;
    logic [15:0] lim;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start         = used_units;
    while (used_units - start < target) begin
      if ($urandom_range(11) == 0) begin
        case ($urandom_range(9))
          0: lim = 16'd0;
          1: lim = 16'd1;
          2: lim = 16'd2;
          3: lim = 16'($urandom_range(3, 8));
          4: lim = 16'($urandom);
          default: lim = 16'hFFFF;
        endcase
        write_limit(lim);
      end
      len = ($urandom_range(3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
      send_string(len, $urandom_range(4) != 0);
    end
  endtask

  initial begin
    send_idle_pct = 38;
    recv_idle_pct = 69;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and each surrogate case
    write_limit(16'hFFFF);
    send_unit(16'h0000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // lowest and highest pairs
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b1);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'h0041, 1'b0);
    // lone trail, lone lead before a plain unit, lead before lead
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    // lead on the last unit; lone lead then a last plain unit
    send_unit(16'hDA00, 1'b1);
    send_unit(16'hD900, 1'b0);
    send_unit(16'h1234, 1'b1);
    // zero limit: only the bare end marker
    write_limit(16'h0000);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b1);
    // flushing the held lead reaches the limit, so its unit is dropped
    write_limit(16'd1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0042, 1'b1);
    // limit lowered mid-string
    write_limit(16'hFFFF);
    send_unit(16'h0050, 1'b0);
    send_unit(16'h0051, 1'b0);
    write_limit(16'd1);
    send_unit(16'h0052, 1'b0);
    send_unit(16'h0053, 1'b1);
    write_limit(16'hFFFF);

    // random part, three idling settings
    run_phase(38, 69, 373);
    write_limit(16'hFFFF);
    run_phase(69, 38, 373);
    write_limit(16'hFFFF);
    run_phase(0, 0, 373);

    wait_drained();
    if (board.errors == 0) begin
      $display("utf16_to_utf32_decoder_unit: match");
    end else begin
      $display("utf16_to_utf32_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> utf16_to_utf32_decoder_unit.f
src/u16d_pkg.sv
src/u16d_front.sv
src/u16d_fifo.sv
src/u16d_back.sv
src/utf16_to_utf32_decoder_unit.sv
verif/tb_utf16_to_utf32_decoder_unit.sv
